// ===== design/sstu_pkg.sv =====
// Package for sensor_sample_to_units: widths, channel codes, light fit tables.
// No dependencies.
`default_nettype none
package sstu_pkg;
	localparam int SAMPLE_BITS_DEF = 10;
	localparam int FRAC_BITS_DEF = 4;
	localparam int VALUE_BITS = 21;
	localparam int NSEG = 7;

	localparam logic [1:0] FUNC_TEMP = 2'd0;
	localparam logic [1:0] FUNC_LIGHT = 2'd1;
	localparam logic [1:0] FUNC_HUMID = 2'd2;

	function automatic logic [11:0] seg_bound(input logic [2:0] i);
		case (i)
			3'd0: seg_bound = 12'd298;
			3'd1: seg_bound = 12'd397;
			3'd2: seg_bound = 12'd567;
			3'd3: seg_bound = 12'd921;
			3'd4: seg_bound = 12'd1990;
			default: seg_bound = 12'd3242;
		endcase
	endfunction

	function automatic logic [19:0] seg_k(input logic [2:0] i);
		case (i)
			3'd0: seg_k = 20'd657900;
			3'd1: seg_k = 20'd597400;
			3'd2: seg_k = 20'd529800;
			3'd3: seg_k = 20'd442500;
			3'd4: seg_k = 20'd343100;
			3'd5: seg_k = 20'd257600;
			default: seg_k = 20'd192100;
		endcase
	endfunction

	function automatic logic [9:0] seg_c(input logic [2:0] i);
		case (i)
			3'd0: seg_c = 10'd707;
			3'd1: seg_c = 10'd504;
			3'd2: seg_c = 10'd334;
			3'd3: seg_c = 10'd180;
			3'd4: seg_c = 10'd72;
			3'd5: seg_c = 10'd29;
			default: seg_c = 10'd9;
		endcase
	endfunction
endpackage
`default_nettype wire

// ===== design/sstu_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing; carries a tag alongside each item.
`default_nettype none
module sstu_div_pipe #(
	parameter int NW = 48,
	parameter int DW = 26,
	parameter int TW = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_vld,
	input  wire logic [NW-1:0] in_num,
	input  wire logic [DW-1:0] in_den,
	input  wire logic [TW-1:0] in_tag,
	output logic               out_vld,
	output logic [NW-1:0]      out_quo,
	output logic [TW-1:0]      out_tag
);
	logic [NW:0]   vld_s;
	logic [NW-1:0] num_s [NW+1];
	logic [DW:0]   rem_s [NW+1];
	logic [DW-1:0] den_s [NW+1];
	logic [TW-1:0] tag_s [NW+1];

	assign vld_s[0] = in_vld;
	assign num_s[0] = in_num;
	assign rem_s[0] = '0;
	assign den_s[0] = in_den;
	assign tag_s[0] = in_tag;

	for (genvar g = 0; g < NW; g++) begin : g_stage
		logic [DW+1:0] trial;
		logic [DW+1:0] diff;
		always_comb begin
			trial = {rem_s[g], num_s[g][NW-1]};
			diff = trial - {2'b00, den_s[g]};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end
		always_ff @(posedge clk) begin
			den_s[g+1] <= den_s[g];
			tag_s[g+1] <= tag_s[g];
			if (!diff[DW+1]) begin
				rem_s[g+1] <= diff[DW:0];
				num_s[g+1] <= {num_s[g][NW-2:0], 1'b1};
			end else begin
				rem_s[g+1] <= trial[DW:0];
				num_s[g+1] <= {num_s[g][NW-2:0], 1'b0};
			end
		end
	end

	assign out_vld = vld_s[NW];
	assign out_quo = num_s[NW];
	assign out_tag = tag_s[NW];
endmodule
`default_nettype wire

// ===== design/sensor_sample_to_units.sv =====
// Top level of sensor_sample_to_units: sample to physical units, pipelined.
// Depends on sstu_pkg and sstu_div_pipe.
//
// Usage: drive func and sample with start high for one cycle; busy is always
// low, so a new item may be started every cycle. Each item yields one result:
// value and saturated appear for exactly one cycle with done high.
// Pipeline: 3 front stages (setup, segment search, numerator build), then the
// divider with one stage per quotient bit (NW stages), then one output stage.
// At the default widths NW = 48.
// Throughput is one item per clock; the divider pipeline sets the latency.
// Temperature: s*500*2^F / FS. Light: r = 10000*(FS-s)/s, segment chosen by
// exact compares r_num <= bound*r_den, then K*r_den*2^F / r_num - C*2^F.
// Humidity: ((10000s-1515FS)*10*2^F)/(636FS), clamped to 100*2^F.
// Special cases (zero resistance, unknown channel, non-positive humidity)
// skip the divider's answer by a tag that travels with the item.
// Reset clears all valid bits; items in flight are dropped.
// The receiver cannot stall; results are never held.
`default_nettype none
module sensor_sample_to_units #(
	parameter int SAMPLE_BITS = sstu_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS = sstu_pkg::FRAC_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  func,
	input  wire logic [9:0]  sample,
	output logic             done,
	output logic [20:0]      value,
	output logic             saturated
);
	localparam int VB = sstu_pkg::VALUE_BITS;
	localparam int SB = SAMPLE_BITS;
	localparam int RW = SB + 14;            // 10000*FS
	localparam int DW = SB + 10;            // 636*FS
	localparam int NW = RW + 20 + FRAC_BITS; // widest numerator
	// the lux divisor is up to RW bits; pick divider width to fit both
	localparam int DVW = (RW > DW) ? RW : DW;
	localparam logic [SB-1:0] FS = {SB{1'b1}};
	localparam logic [RW-1:0] FLOOR_R = RW'(4990000);

	// tag: kind of special handling after the divider
	localparam logic [1:0] T_DIV = 2'd0;
	localparam logic [1:0] T_ZERO = 2'd1;
	localparam logic [1:0] T_SAT = 2'd2;
	localparam logic [1:0] T_LUX = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] seg;
		logic       hum;
	} tag_t;

	assign busy = 1'b0;

	// stage 1: form r numerator/denominator and humidity terms
	logic            vld_s1;
	logic [1:0]      func_s1;
	logic [SB-1:0]   s_s1;
	logic [RW-1:0]   rnum_s1;
	logic [SB-1:0]   rden_s1;
	logic            fl_s1;
	logic [RW:0]     hpos_s1;
	logic [RW:0]     hoff_s1;

	logic [SB-1:0] s_in;
	assign s_in = SB'(sample);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		func_s1 <= func;
		s_s1 <= s_in;
		fl_s1 <= ((SB+9)'(s_in) * (SB+9)'(500)) < (SB+9)'(FS);
		rnum_s1 <= RW'(FS - s_in) * RW'(10000);
		rden_s1 <= s_in;
		hpos_s1 <= (RW+1)'(s_in) * (RW+1)'(10000);
		hoff_s1 <= (RW+1)'(FS) * (RW+1)'(1515);
	end

	// stage 2: segment search, humidity difference
	logic            vld_s2;
	logic [1:0]      func_s2;
	logic [SB-1:0]   s_s2;
	logic [RW-1:0]   rnum_s2;
	logic [SB-1:0]   rden_s2;
	logic [2:0]      seg_s2;
	logic            zero_s2;
	logic            hneg_s2;
	logic [RW:0]     hdif_s2;

	logic [RW-1:0] rn;
	logic [SB-1:0] rd;
	logic [2:0]    seg;
	always_comb begin
		rn = fl_s1 ? FLOOR_R : rnum_s1;
		rd = fl_s1 ? SB'(1) : rden_s1;
		seg = 3'd6;
		for (int i = 5; i >= 0; i--) begin
			if ((RW+12)'(rn) <= (RW+12)'(sstu_pkg::seg_bound(3'(i))) * (RW+12)'(rd))
				seg = 3'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		func_s2 <= func_s1;
		s_s2 <= s_s1;
		rnum_s2 <= rn;
		rden_s2 <= rd;
		seg_s2 <= seg;
		zero_s2 <= !fl_s1 && (s_s1 == FS);
		hneg_s2 <= hpos_s1 <= hoff_s1;
		hdif_s2 <= hpos_s1 - hoff_s1;
	end

	// stage 3: numerator and divisor per channel
	logic            vld_s3;
	logic [NW-1:0]   num_s3;
	logic [DVW-1:0]  den_s3;
	tag_t            tag_s3;

	logic [NW-1:0]   num_nx;
	logic [DVW-1:0]  den_nx;
	tag_t            tag_nx;

	always_comb begin
		tag_nx.seg = seg_s2;
		tag_nx.hum = 1'b0;
		tag_nx.kind = T_ZERO;
		den_nx = DVW'(1);
		num_nx = '0;
		case (func_s2)
			sstu_pkg::FUNC_TEMP: begin
				tag_nx.kind = T_DIV;
				num_nx = (NW'(s_s2) * NW'(500)) << FRAC_BITS;
				den_nx = DVW'(FS);
			end
			sstu_pkg::FUNC_LIGHT: begin
				tag_nx.kind = zero_s2 ? T_SAT : T_LUX;
				num_nx = (NW'(sstu_pkg::seg_k(seg_s2)) * NW'(rden_s2)) << FRAC_BITS;
				den_nx = DVW'(rnum_s2);
			end
			sstu_pkg::FUNC_HUMID: begin
				tag_nx.kind = hneg_s2 ? T_ZERO : T_DIV;
				tag_nx.hum = 1'b1;
				num_nx = (NW'(hdif_s2) * NW'(10)) << FRAC_BITS;
				den_nx = DVW'(FS) * DVW'(636);
			end
			default: begin
				tag_nx.kind = T_ZERO;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		tag_s3 <= tag_nx;
		den_s3 <= den_nx;
		num_s3 <= num_nx;
	end

	logic          dv_vld;
	logic [NW-1:0] dv_quo;
	tag_t          dv_tag;

	sstu_div_pipe #(
		.NW(NW),
		.DW(DVW),
		.TW($bits(tag_t))
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_vld(vld_s3),
		.in_num(num_s3),
		.in_den(den_s3),
		.in_tag(tag_s3),
		.out_vld(dv_vld),
		.out_quo(dv_quo),
		.out_tag(dv_tag)
	);

	// output stage: offset, clamps
	localparam logic [NW-1:0] HMAX = NW'(100) << FRAC_BITS;
	localparam logic [NW-1:0] VMAX = NW'({VB{1'b1}});
	logic [NW-1:0] c_sh;
	logic [NW-1:0] q;
	logic [VB-1:0] v_nx;
	logic          sat_nx;
	always_comb begin
		c_sh = NW'(sstu_pkg::seg_c(dv_tag.seg)) << FRAC_BITS;
		q = dv_quo;
		v_nx = '0;
		sat_nx = 1'b0;
		case (dv_tag.kind)
			T_DIV: begin
				if (dv_tag.hum && q > HMAX)
					q = HMAX;
				v_nx = (q > VMAX) ? VMAX[VB-1:0] : q[VB-1:0];
			end
			T_LUX: begin
				if (q > c_sh) begin
					q = q - c_sh;
					if (q > VMAX) begin
						v_nx = VMAX[VB-1:0];
						sat_nx = 1'b1;
					end else begin
						v_nx = q[VB-1:0];
					end
				end
			end
			T_SAT: begin
				v_nx = VMAX[VB-1:0];
				sat_nx = 1'b1;
			end
			default: begin
				v_nx = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		value <= v_nx;
		saturated <= sat_nx;
	end
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for sensor_sample_to_units: random and directed samples on all channels,
// each result checked against an in-bench integer model. Depends on sstu_pkg and the RTL.
`default_nettype none
module testbench;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam logic [1:0] FUNC_NONE = 2'd3;
	localparam logic [20:0] VMAX = 21'h1FFFFF;

	typedef struct packed {
		logic [1:0] func;
		logic [9:0] sample;
	} sample_item_t;

	typedef struct packed {
		logic [20:0] value;
		logic        saturated;
	} units_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] func = '0;
	logic [9:0] sample = '0;
	wire logic busy;
	wire logic done;
	wire logic [20:0] value;
	wire logic saturated;

	sample_item_t pending_items[$];
	units_t expected_units[$];
	int errors = 0;
	int accepted = 0;
	int checked = 0;
	int idle_pct = 21;      // sender idle chance, per hundred
	int quiet_cycles = 0;

	sensor_sample_to_units u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .sample(sample), .done(done),
		.value(value), .saturated(saturated)
	);

	always #1 clk = ~clk;

	// Light fit tables, indexed by segment
	function automatic longint lux_k(int i);
		longint k[7] = '{657900, 597400, 529800, 442500, 343100, 257600, 192100};
		return k[i];
	endfunction

	function automatic longint lux_c(int i);
		longint c[7] = '{707, 504, 334, 180, 72, 29, 9};
		return c[i];
	endfunction

	function automatic longint lux_bound(int i);
		longint b[6] = '{298, 397, 567, 921, 1990, 3242};
		return b[i];
	endfunction

	// Physical value of one sample, unsigned, 4 fraction bits
	function automatic units_t to_units(sample_item_t it);
		longint fs, s, rnum, rden, q, c, pos, off;
		int i;
		units_t u;
		fs = 1023;
		s = it.sample;
		u = '0;
		case (it.func)
			sstu_pkg::FUNC_TEMP: u.value = 21'(((s * 500) << 4) / fs);
			sstu_pkg::FUNC_HUMID: begin
				pos = 10000 * s;
				off = 1515 * fs;
				if (pos > off) begin
					q = (((pos - off) * 10) << 4) / (636 * fs);
					if (q > (100 << 4))
						q = 100 << 4;
					u.value = 21'(q);
				end
			end
			sstu_pkg::FUNC_LIGHT: begin
				if (s >= fs) begin
					// zero resistance: infinite lux
					u.value = VMAX;
					u.saturated = 1'b1;
				end else begin
					if (s * 500 < fs) begin
						// voltage floored at 0.01 V
						rnum = 4990000;
						rden = 1;
					end else begin
						rnum = 10000 * (fs - s);
						rden = s;
					end
					i = 0;
					while (i < 6 && rnum > lux_bound(i) * rden)
						i++;
					q = ((lux_k(i) * rden) << 4) / rnum;
					c = lux_c(i) << 4;
					if (q > c) begin
						q -= c;
						if (q > VMAX) begin
							u.value = VMAX;
							u.saturated = 1'b1;
						end else begin
							u.value = 21'(q);
						end
					end
				end
			end
			default: u = '0;
		endcase
		return u;
	endfunction

	// Driver: one item per accepting edge, random gaps
	always @(posedge clk) begin
		sample_item_t it;
		if (arst_n) begin
			if (start && !busy) begin
				accepted <= accepted + 1;
			end
			if (!(start && busy)) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
					it = pending_items.pop_front();
					start <= 1'b1;
					func <= it.func;
					sample <= it.sample;
					expected_units.push_back(to_units(it));
				end else begin
					start <= 1'b0;
					func <= 2'($urandom);
					sample <= 10'($urandom);
				end
			end
		end
	end

	// Monitor: every strobed result against the oldest expectation
	always @(posedge clk) begin
		units_t exp_u;
		if (arst_n && done) begin
			checked <= checked + 1;
			if (expected_units.size() == 0) begin
				$display("%0t: unexpected result value=%0d saturated=%0b",
					$time, value, saturated);
				errors = errors + 1;
			end else begin
				exp_u = expected_units.pop_front();
				if (value !== exp_u.value) begin
					$display("%0t: value mismatch expected %0d actual %0d",
						$time, exp_u.value, value);
					errors = errors + 1;
				end
				if (saturated !== exp_u.saturated) begin
					$display("%0t: saturated mismatch expected %0b actual %0b",
						$time, exp_u.saturated, saturated);
					errors = errors + 1;
				end
			end
		end
	end

	// Watchdog: cycles with nothing accepted on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired at %0t", $time);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic add_item(logic [1:0] f, logic [9:0] s);
		sample_item_t it;
		it.func = f;
		it.sample = s;
		pending_items.push_back(it);
	endtask

	task automatic add_random(int n);
		int r;
		logic [1:0] f;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			f = (r < 5) ? FUNC_NONE : 2'($urandom_range(2));
			// bias toward range edges now and then
			if ($urandom_range(9) == 0)
				add_item(f, $urandom_range(1) ? 10'($urandom_range(3))
					: 10'(1020 + $urandom_range(3)));
			else
				add_item(f, 10'($urandom));
		end
	endtask

	task automatic drain();
		while (pending_items.size() > 0 || expected_units.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, voltage floor, zero resistance, humidity clamps
		add_item(sstu_pkg::FUNC_TEMP, 10'd0);
		add_item(sstu_pkg::FUNC_TEMP, 10'd1023);
		add_item(sstu_pkg::FUNC_TEMP, 10'h2AA);
		add_item(sstu_pkg::FUNC_TEMP, 10'h155);
		add_item(sstu_pkg::FUNC_LIGHT, 10'd0);
		add_item(sstu_pkg::FUNC_LIGHT, 10'd1);
		add_item(sstu_pkg::FUNC_LIGHT, 10'd2);
		add_item(sstu_pkg::FUNC_LIGHT, 10'd3);
		add_item(sstu_pkg::FUNC_LIGHT, 10'd1022);
		add_item(sstu_pkg::FUNC_LIGHT, 10'd1023);
		add_item(sstu_pkg::FUNC_LIGHT, 10'd791);   // near last segment bound
		add_item(sstu_pkg::FUNC_LIGHT, 10'd240);   // upper segment
		add_item(sstu_pkg::FUNC_LIGHT, 10'd512);
		add_item(sstu_pkg::FUNC_HUMID, 10'd0);
		add_item(sstu_pkg::FUNC_HUMID, 10'd155);
		add_item(sstu_pkg::FUNC_HUMID, 10'd156);
		add_item(sstu_pkg::FUNC_HUMID, 10'd800);
		add_item(sstu_pkg::FUNC_HUMID, 10'd1023);
		add_item(FUNC_NONE, 10'd0);
		add_item(FUNC_NONE, 10'd1023);

		// Sender idles 21%, then 67%, then back to back
		idle_pct = 21;
		add_random(230);
		drain();
		idle_pct = 67;
		add_random(230);
		drain();
		idle_pct = 0;
		add_random(240);
		drain();
		repeat (100) @(posedge clk);

		$display("Sent %0d items over all channels and sample extremes; %0d results checked.",
			accepted, checked);
		if (errors == 0 && expected_units.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire
